// File: rtl/core/assert_macros.svh
// Assertion macros shared by the grid distance unit RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gdu_pkg.sv
// Types, widths and codes of the grid distance unit.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package gdu_pkg;

    localparam int COORD_BITS  = 16;
    localparam int COST_BITS   = 8;
    localparam int DIST_BITS   = 25;
    localparam int CMD_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int OCT_BITS  = COST_BITS + COORD_BITS + 1;
    localparam int RES_A     = (OCT_BITS > ROOT_BITS) ? OCT_BITS : ROOT_BITS;
    localparam int RES_BITS  = (RES_A > DIST_BITS) ? RES_A : DIST_BITS;

    localparam int LATENCY   = ROOT_BITS + 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_BITS-1:0] CMD_EUCLID = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CHEB   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_OCTILE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_STRAIGHT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIAGONAL = 2'd1;

    localparam logic [COST_BITS-1:0] STRAIGHT_RESET = 8'd10;
    localparam logic [COST_BITS-1:0] DIAGONAL_RESET = 8'd14;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
    } item_t;

    function automatic logic [DIST_BITS-1:0] sat_dist(input logic [RES_BITS-1:0] v);
        logic [DIST_BITS-1:0] r;
        if (v > RES_BITS'(DIST_MAX))
            r = DIST_MAX;
        else
            r = v[DIST_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/grid_distance_unit_top.sv
// Top level of the grid distance unit: configuration registers and wiring
// of front end, queue and back end. Depends on gdu_pkg and assert_macros.svh.
//
// Use:
//  - Command channel: drive cmd, ax, ay, bx, by with start high; the item is
//    taken at a rising edge where start is high and busy is low. cmd selects
//    floor Euclidean distance, Chebyshev distance or octile cost; cmd 3
//    yields zero.
//  - Result channel: done is high for one cycle with distance valid. The
//    receiver cannot stall; results leave in command order.
//  - Configuration: cfg_valid/cfg_ready transfer with cfg_index and cfg_data;
//    index 0 is straight_cost, index 1 diagonal_cost, others are dropped.
//    cfg_ready is always high. Write only while no command is in flight.
//  - Throughput: one command per cycle, every cycle; busy stays low since
//    the back end never stalls and drains the queue each cycle.
//  - Result path: an accepted item passes the queue slot, stages A and B,
//    the root entry stage and the square root pipeline that resolves one
//    root bit per stage, then the done/distance output register.
//  - Reset: rst_n clears all control state and loads the costs 10 and 14;
//    no clearing pass, the block takes commands right after reset.
`default_nettype none

`include "assert_macros.svh"

module grid_distance_unit_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [gdu_pkg::CMD_BITS-1:0]      cmd,
    input  wire logic [gdu_pkg::COORD_BITS-1:0]    ax,
    input  wire logic [gdu_pkg::COORD_BITS-1:0]    ay,
    input  wire logic [gdu_pkg::COORD_BITS-1:0]    bx,
    input  wire logic [gdu_pkg::COORD_BITS-1:0]    by,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gdu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [gdu_pkg::COST_BITS-1:0]     cfg_data,
    output logic                                   done,
    output logic [gdu_pkg::DIST_BITS-1:0]          distance
);
    import gdu_pkg::*;

    logic [COST_BITS-1:0] straight_reg;
    logic [COST_BITS-1:0] straight_next;
    logic [COST_BITS-1:0] diagonal_reg;
    logic [COST_BITS-1:0] diagonal_next;

    logic  push;
    logic  full;
    logic  empty;
    item_t front_item;
    item_t queue_item;

    assign cfg_ready = 1'b1;
    assign busy      = full;

    always_comb
    begin
        straight_next = straight_reg;
        diagonal_next = diagonal_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STRAIGHT: straight_next = cfg_data;
                REG_DIAGONAL: diagonal_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg <= STRAIGHT_RESET;
            diagonal_reg <= DIAGONAL_RESET;
        end
        else
        begin
            straight_reg <= straight_next;
            diagonal_reg <= diagonal_next;
        end
    end

    gdu_front u_front (
        .start (start),
        .full  (full),
        .cmd   (cmd),
        .ax    (ax),
        .ay    (ay),
        .bx    (bx),
        .by    (by),
        .push  (push),
        .item  (front_item)
    );

    gdu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (!empty),
        .item_out (queue_item),
        .empty    (empty),
        .full     (full)
    );

    gdu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!empty),
        .item          (queue_item),
        .straight_cost (straight_reg),
        .diagonal_cost (diagonal_reg),
        .done          (done),
        .distance      (distance)
    );

    `ASSERT_IMPLIES(a_fixed_latency, start && !busy, ##LATENCY done, "result missing at fixed latency")

endmodule

`default_nettype wire

// File: rtl/core/gdu_front.sv
// Front end: takes a command and two points, forms |dx| and |dy|.
// Depends on gdu_pkg; feeds gdu_queue.
`default_nettype none

module gdu_front (
    input  wire logic                           start,
    input  wire logic                           full,
    input  wire logic [gdu_pkg::CMD_BITS-1:0]   cmd,
    input  wire logic [gdu_pkg::COORD_BITS-1:0] ax,
    input  wire logic [gdu_pkg::COORD_BITS-1:0] ay,
    input  wire logic [gdu_pkg::COORD_BITS-1:0] bx,
    input  wire logic [gdu_pkg::COORD_BITS-1:0] by,
    output logic                                push,
    output gdu_pkg::item_t                      item
);
    import gdu_pkg::*;

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;

    assign diff_x = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
    assign diff_y = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});

    always_comb
    begin
        push     = start && !full;
        item.cmd = cmd;
        item.dx  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
        item.dy  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/gdu_queue.sv
// Short queue of classified items between front end and back end.
// Depends on gdu_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module gdu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gdu_pkg::item_t item_in,
    input  wire logic           pop,
    output gdu_pkg::item_t      item_out,
    output logic                empty,
    output logic                full
);
    import gdu_pkg::*;

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_BITS'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_IMPLIES(a_no_lost_push, push, !full, "push into a full queue")

endmodule

`default_nettype wire

// File: rtl/core/gdu_back.sv
// Back end: squares, octile products, pipelined integer square root,
// result select and saturation. Depends on gdu_pkg.
`default_nettype none

module gdu_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire gdu_pkg::item_t                item,
    input  wire logic [gdu_pkg::COST_BITS-1:0] straight_cost,
    input  wire logic [gdu_pkg::COST_BITS-1:0] diagonal_cost,
    output logic                               done,
    output logic [gdu_pkg::DIST_BITS-1:0]      distance
);
    import gdu_pkg::*;

    // stage A: squares and ordering
    logic                  vld_a_reg;
    logic [CMD_BITS-1:0]   cmd_a_reg;
    logic [2*COORD_BITS-1:0] sqx_a_reg;
    logic [2*COORD_BITS-1:0] sqy_a_reg;
    logic [COORD_BITS-1:0] hi_a_reg;
    logic [COORD_BITS-1:0] lo_a_reg;
    logic [COORD_BITS-1:0] span_a_reg;
    logic [COORD_BITS-1:0] hi_a_next;
    logic [COORD_BITS-1:0] lo_a_next;

    // stage B: sum of squares and cost products
    logic                  vld_b_reg;
    logic [CMD_BITS-1:0]   cmd_b_reg;
    logic [SQ_BITS-1:0]    sum_b_reg;
    logic [COORD_BITS-1:0] hi_b_reg;
    logic [COST_BITS+COORD_BITS-1:0] octs_b_reg;
    logic [COST_BITS+COORD_BITS-1:0] octd_b_reg;

    // root stages, element 0 is the entry stage
    logic                s_vld_reg  [ROOT_BITS+1];
    logic [CMD_BITS-1:0] s_cmd_reg  [ROOT_BITS+1];
    logic [RAD_BITS-1:0] s_rad_reg  [ROOT_BITS+1];
    logic [REM_BITS-1:0] s_rem_reg  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] s_root_reg [ROOT_BITS+1];
    logic [RES_BITS-1:0] s_alt_reg  [ROOT_BITS+1];
    logic [RES_BITS-1:0] alt_next;

    logic                 done_reg;
    logic [DIST_BITS-1:0] distance_reg;
    logic [DIST_BITS-1:0] distance_next;

    always_comb
    begin
        if (item.dx > item.dy)
        begin
            hi_a_next = item.dx;
            lo_a_next = item.dy;
        end
        else
        begin
            hi_a_next = item.dy;
            lo_a_next = item.dx;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_a_reg  <= item.cmd;
        sqx_a_reg  <= item.dx * item.dx;
        sqy_a_reg  <= item.dy * item.dy;
        hi_a_reg   <= hi_a_next;
        lo_a_reg   <= lo_a_next;
        span_a_reg <= hi_a_next - lo_a_next;

        cmd_b_reg  <= cmd_a_reg;
        sum_b_reg  <= SQ_BITS'(sqx_a_reg) + SQ_BITS'(sqy_a_reg);
        hi_b_reg   <= hi_a_reg;
        octs_b_reg <= straight_cost * span_a_reg;
        octd_b_reg <= diagonal_cost * lo_a_reg;
    end

    always_comb
    begin
        unique case (cmd_b_reg)
            CMD_CHEB:   alt_next = RES_BITS'(hi_b_reg);
            CMD_OCTILE: alt_next = RES_BITS'(OCT_BITS'(octs_b_reg) + OCT_BITS'(octd_b_reg));
            default:    alt_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_cmd_reg[0]  <= cmd_b_reg;
        s_rad_reg[0]  <= RAD_BITS'(sum_b_reg);
        s_rem_reg[0]  <= '0;
        s_root_reg[0] <= '0;
        s_alt_reg[0]  <= alt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg    <= 1'b0;
            vld_b_reg    <= 1'b0;
            s_vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_a_reg    <= in_valid;
            vld_b_reg    <= vld_a_reg;
            s_vld_reg[0] <= vld_b_reg;
        end
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root
        logic [REM_BITS-1:0]  rem_sh;
        logic [REM_BITS-1:0]  trial;
        logic [REM_BITS-1:0]  rem_next;
        logic [ROOT_BITS-1:0] root_next;

        always_comb
        begin
            rem_sh = {s_rem_reg[k][REM_BITS-3:0], s_rad_reg[k][RAD_BITS-1-2*k -: 2]};
            trial  = {s_root_reg[k], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {s_root_reg[k][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {s_root_reg[k][ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            s_cmd_reg[k+1]  <= s_cmd_reg[k];
            s_rad_reg[k+1]  <= s_rad_reg[k];
            s_rem_reg[k+1]  <= rem_next;
            s_root_reg[k+1] <= root_next;
            s_alt_reg[k+1]  <= s_alt_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_vld_reg[k+1] <= 1'b0;
            else
                s_vld_reg[k+1] <= s_vld_reg[k];
        end
    end

    always_comb
    begin
        if (s_cmd_reg[ROOT_BITS] == CMD_EUCLID)
            distance_next = sat_dist(RES_BITS'(s_root_reg[ROOT_BITS]));
        else
            distance_next = sat_dist(s_alt_reg[ROOT_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s_vld_reg[ROOT_BITS];
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
    end

    assign done     = done_reg;
    assign distance = distance_reg;

endmodule

`default_nettype wire
